### hdl/trie_insert_lookup_unit_assert.svh
// assertion macros for the checker file tli_check.sv
`ifndef TRIE_INSERT_LOOKUP_UNIT_ASSERT_SVH
`define TRIE_INSERT_LOOKUP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TLI_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tli check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define TLI_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tli check failed");

`endif

### hdl/tli_pkg.sv
package tli_pkg;

  localparam int LETTER_COUNT = 26;
  localparam logic [4:0] LAST_LETTER = 5'd25;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [10:0] nodes_used;
  } result_t;

endpackage

### hdl/tli_if.sv
interface tli_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [4:0] letter;
  logic       last_letter;

  modport source (output valid, output operation, output letter, output last_letter,
                  input ready);
  modport sink (input valid, input operation, input letter, input last_letter,
                output ready);
endinterface

interface tli_out_if;
  logic             valid;
  logic             ready;
  tli_pkg::status_t status;
  logic [10:0]      nodes_used;

  modport source (output valid, output status, output nodes_used, input ready);
  modport sink (input valid, input status, input nodes_used, output ready);
endinterface

### hdl/trie_insert_lookup_unit.sv
// array trie over the letters a to z, one letter per input beat
// req carries operation (insert or lookup), letter and last_letter; a word is
// a run of beats ending with last_letter high. rsp carries one beat per word:
// status (inserted, found, not found, table full) and nodes_used.
// for each letter, the slot of the current node is read from the node memory
// in the accept cycle (S_IDLE) and resolved, with a possible write back of a
// new child and the word mark, in S_EXEC, which holds a last letter while the
// output register is busy. req.ready is high only in S_IDLE, so a letter is
// taken only once the one before it is resolved; rsp.valid is registered.
// reset starts a clearing pass over all NODE_COUNT*26 slots of the node memory
// (26624 at the default size), during which req.ready stays low. nodes_used
// restarts at one.
// the result sits in an output register; a new word can be fed while it
// waits. if rsp is stalled when the next last letter resolves, the block
// holds that letter and takes no more input until rsp accepts the beat.
// when all NODE_COUNT nodes are taken, inserts needing a new node report full
module trie_insert_lookup_unit #(
  parameter int NODE_COUNT = 1024
) (
  input logic        clk,
  input logic        rst,
  tli_in_if.sink     req,
  tli_out_if.source  rsp
);

  localparam int NodeW = $clog2(NODE_COUNT);
  localparam int SlotTotal = NODE_COUNT * tli_pkg::LETTER_COUNT;
  localparam int AddrW = $clog2(SlotTotal);

  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [NodeW:0]   mem_wdata, mem_rdata;
  logic             hold;
  tli_pkg::result_t res;

  logic             out_valid, out_valid_next;
  tli_pkg::status_t out_status;
  logic [10:0]      out_nodes;

  tli_walk #(
    .NODE_COUNT(NODE_COUNT)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .hold     (hold),
    .res      (res)
  );

  tli_node_mem #(
    .DEPTH (SlotTotal),
    .ADDR_W(AddrW),
    .DATA_W(NodeW + 1)
  ) u_node_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // output register is busy while its beat is not taken
  assign hold           = out_valid && !rsp.ready;
  assign out_valid_next = res.valid || (out_valid && !rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status <= res.status;
      out_nodes  <= res.nodes_used;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.nodes_used = out_nodes;

endmodule

### hdl/tli_node_mem.sv
module tli_node_mem #(
  parameter int DEPTH = 26624,
  parameter int ADDR_W = 15,
  parameter int DATA_W = 11
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/tli_walk.sv
module tli_walk #(
  parameter int NODE_COUNT = 1024,
  localparam int NodeW = $clog2(NODE_COUNT),
  localparam int SlotTotal = NODE_COUNT * tli_pkg::LETTER_COUNT,
  localparam int AddrW = $clog2(SlotTotal)
) (
  input  logic              clk,
  input  logic              rst,
  tli_in_if.sink            req,
  output logic              mem_we,
  output logic [AddrW-1:0]  mem_waddr,
  output logic [NodeW:0]    mem_wdata,
  output logic              mem_re,
  output logic [AddrW-1:0]  mem_raddr,
  input  logic [NodeW:0]    mem_rdata,
  input  logic              hold,
  output tli_pkg::result_t  res
);

  tli_pkg::state_t state, state_next;
  logic [AddrW-1:0] clr_addr, clr_addr_next;
  logic [NodeW-1:0] cur_node, cur_node_next;
  logic             broken, broken_next;
  logic [NodeW:0]   next_free, next_free_next;
  logic             op_q, last_q;
  logic [AddrW-1:0] addr_q;

  logic             accept, step, clr_done, full;
  logic [4:0]       letter_sat;
  logic [AddrW-1:0] rd_addr;

  logic [NodeW-1:0] child, new_child, cur_after;
  logic             mark, broken_after, ex_write;
  logic [NodeW:0]   free_after, ex_wdata;
  tli_pkg::status_t ex_status;

  assign accept   = req.valid && req.ready;
  assign step     = (state == tli_pkg::S_EXEC) && !(last_q && hold);
  assign clr_done = (clr_addr == AddrW'(SlotTotal - 1));
  assign full     = (next_free == (NodeW + 1)'(NODE_COUNT));

  assign letter_sat = (req.letter > tli_pkg::LAST_LETTER) ? tli_pkg::LAST_LETTER : req.letter;
  assign rd_addr    = AddrW'(cur_node) * AddrW'(tli_pkg::LETTER_COUNT) + AddrW'(letter_sat);

  // resolve one letter against the slot read when it was accepted
  always_comb begin
    child        = mem_rdata[NodeW-1:0];
    mark         = mem_rdata[NodeW];
    new_child    = child;
    ex_write     = 1'b0;
    ex_wdata     = mem_rdata;
    cur_after    = cur_node;
    broken_after = broken;
    free_after   = next_free;
    ex_status    = tli_pkg::ST_INSERTED;
    if (broken) begin
      ex_status = (op_q == tli_pkg::OP_INSERT) ? tli_pkg::ST_FULL : tli_pkg::ST_NOT_FOUND;
    end else if (op_q == tli_pkg::OP_INSERT) begin
      if ((child == '0) && full) begin
        broken_after = 1'b1;
        ex_status    = tli_pkg::ST_FULL;
      end else begin
        if (child == '0) begin
          new_child  = next_free[NodeW-1:0];
          free_after = next_free + (NodeW + 1)'(1);
        end
        ex_write  = (child == '0) || last_q;
        ex_wdata  = {mark | last_q, new_child};
        cur_after = new_child;
      end
    end else begin
      if (child == '0) begin
        broken_after = 1'b1;
        ex_status    = tli_pkg::ST_NOT_FOUND;
      end else begin
        cur_after = child;
        ex_status = mark ? tli_pkg::ST_FOUND : tli_pkg::ST_NOT_FOUND;
      end
    end
    // end of word returns to the root
    if (last_q) begin
      cur_after    = '0;
      broken_after = 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tli_pkg::S_CLEAR: begin
        if (clr_done) state_next = tli_pkg::S_IDLE;
      end
      tli_pkg::S_IDLE: begin
        if (accept) state_next = tli_pkg::S_EXEC;
      end
      tli_pkg::S_EXEC: begin
        if (step) state_next = tli_pkg::S_IDLE;
      end
      default: state_next = tli_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    req.ready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = addr_q;
    mem_wdata      = ex_wdata;
    res.valid      = 1'b0;
    res.status     = ex_status;
    res.nodes_used = 11'(free_after);
    case (state)
      tli_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      tli_pkg::S_IDLE: begin
        req.ready = 1'b1;
      end
      tli_pkg::S_EXEC: begin
        mem_we    = step && ex_write;
        res.valid = step && last_q;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign mem_re    = accept;
  assign mem_raddr = rd_addr;

  always_comb begin
    clr_addr_next  = clr_addr;
    cur_node_next  = cur_node;
    broken_next    = broken;
    next_free_next = next_free;
    if (state == tli_pkg::S_CLEAR) begin
      clr_addr_next = clr_addr + AddrW'(1);
    end
    if (step) begin
      cur_node_next  = cur_after;
      broken_next    = broken_after;
      next_free_next = free_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tli_pkg::S_CLEAR;
      clr_addr  <= '0;
      cur_node  <= '0;
      broken    <= 1'b0;
      next_free <= (NodeW + 1)'(1);
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      cur_node  <= cur_node_next;
      broken    <= broken_next;
      next_free <= next_free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= req.operation;
      last_q <= req.last_letter;
      addr_q <= rd_addr;
    end
  end

endmodule

### hdl/tli_check.sv
`include "trie_insert_lookup_unit_assert.svh"

module tli_check (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_last_letter,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [10:0] rsp_nodes_used
);

  // a stalled result beat stays up
  `TLI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

  // nodes_used of a stalled beat does not move
  `TLI_ASSERT_NEXT(a_rsp_nodes_stable, rsp_valid && !rsp_ready, $stable(rsp_nodes_used))

  // req.ready drops after each accepted letter while its slot is resolved
  `TLI_ASSERT_NEXT(a_req_gap, req_valid && req_ready, !req_ready)

  // a fresh result beat traces back to an accepted last letter, through S_EXEC and the output register
  `TLI_ASSERT_SAME(a_rsp_origin, $rose(rsp_valid), $past($past(req_valid && req_ready && req_last_letter)))

endmodule

bind trie_insert_lookup_unit tli_check u_tli_check (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_last_letter(req.last_letter),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_nodes_used (rsp.nodes_used)
);

### bench/tb_trie_insert_lookup_unit.sv
module tb_trie_insert_lookup_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_COUNT = 1024;
  localparam int SLOT_COUNT = NODE_COUNT * tli_pkg::LETTER_COUNT;
  localparam int MAX_WORD   = 24;
  localparam int CYCLE_CAP  = 600000;
  localparam int HOLD_LEN   = 400;

  typedef struct packed {
    logic       op;
    logic [4:0] letter;
    logic       last;
  } letter_beat_t;

  typedef struct packed {
    logic [4:0]                 len;
    logic [MAX_WORD-1:0][4:0]   ch;
  } word_t;

  typedef struct packed {
    tli_pkg::status_t status;
    logic [10:0]      nodes_used;
  } trie_answer_t;

  typedef enum logic [1:0] {
    W_INSERT,
    W_LOOKUP,
    W_MIXED
  } word_mode_t;

  logic clk = 1'b0;
  logic rst;

  tli_in_if  req_if ();
  tli_out_if rsp_if ();

  trie_insert_lookup_unit #(
    .NODE_COUNT(NODE_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // trie mirror
  bit   [9:0]  child_tbl [0:SLOT_COUNT-1];
  bit          mark_tbl  [0:SLOT_COUNT-1];
  logic [10:0] free_next = 11'd1;
  logic [9:0]  walk_node = 10'd0;
  bit          walk_broken = 1'b0;

  letter_beat_t letters_todo[$];
  trie_answer_t answers_due[$];
  word_t        lexicon[$];

  int letters_pushed = 0;
  int letters_sent   = 0;
  int results_got    = 0;
  int fail_count     = 0;
  int status_seen [4];
  int send_gap   = 0;
  int recv_stall = 0;
  bit send_calm  = 1'b0;
  bit recv_calm  = 1'b0;
  int hold_left  = 0;
  int holds_done = 0;
  int next_hold_at = 25;
  int cycle_cnt  = 0;

  // walks one letter through the mirror, returns 1 when the letter ends a word
  function automatic bit trie_walk(input logic op, input logic [4:0] letter_in,
                                   input logic last, output trie_answer_t ans);
    int               idx;
    logic [4:0]       l;
    logic [9:0]       kid;
    tli_pkg::status_t st;
    l = (letter_in > tli_pkg::LAST_LETTER) ? tli_pkg::LAST_LETTER : letter_in;
    idx = int'(walk_node) * tli_pkg::LETTER_COUNT + int'(l);
    st = tli_pkg::ST_INSERTED;
    if (!walk_broken) begin
      kid = child_tbl[idx];
      if (op == tli_pkg::OP_INSERT) begin
        if (kid == 10'd0) begin
          if (free_next >= NODE_COUNT) begin
            walk_broken = 1'b1;
          end else begin
            kid = free_next[9:0];
            child_tbl[idx] = kid;
            free_next = free_next + 11'd1;
          end
        end
        if (!walk_broken) begin
          if (last) mark_tbl[idx] = 1'b1;
          walk_node = kid;
        end
        st = walk_broken ? tli_pkg::ST_FULL : tli_pkg::ST_INSERTED;
      end else begin
        if (kid == 10'd0) begin
          walk_broken = 1'b1;
          st = tli_pkg::ST_NOT_FOUND;
        end else begin
          st = mark_tbl[idx] ? tli_pkg::ST_FOUND : tli_pkg::ST_NOT_FOUND;
          walk_node = kid;
        end
      end
    end else begin
      st = (op == tli_pkg::OP_INSERT) ? tli_pkg::ST_FULL : tli_pkg::ST_NOT_FOUND;
    end
    ans.status = st;
    ans.nodes_used = free_next;
    if (last) begin
      walk_node = 10'd0;
      walk_broken = 1'b0;
    end
    return last;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  function automatic word_t rand_word(input int min_len, input int max_len,
                                      input int alpha);
    word_t w;
    w = '0;
    w.len = 5'($urandom_range(min_len, max_len));
    for (int i = 0; i < w.len; i++) begin
      // now and then a letter past z, which folds onto z
      if ($urandom_range(0, 19) == 0) w.ch[i] = 5'($urandom_range(26, 31));
      else w.ch[i] = 5'($urandom_range(0, alpha - 1));
    end
    return w;
  endfunction

  task automatic push_letter(input logic op, input logic [4:0] letter, input logic last);
    letter_beat_t b;
    b.op = op;
    b.letter = letter;
    b.last = last;
    letters_todo = {letters_todo, b};
    letters_pushed++;
  endtask

  task automatic push_word(input word_t w, input word_mode_t mode);
    logic op;
    for (int i = 0; i < w.len; i++) begin
      case (mode)
        W_INSERT: op = tli_pkg::OP_INSERT;
        W_LOOKUP: op = tli_pkg::OP_LOOKUP;
        default:  op = $urandom_range(0, 1) ? tli_pkg::OP_LOOKUP : tli_pkg::OP_INSERT;
      endcase
      push_letter(op, w.ch[i], i == w.len - 1);
    end
  endtask

  task automatic keep_word(input word_t w);
    if (lexicon.size() < 300) lexicon = {lexicon, w};
  endtask

  task automatic mixed_words(input int budget);
    int    used;
    int    r;
    word_t w;
    used = 0;
    while (used < budget) begin
      r = $urandom_range(0, 99);
      if (r < 35 || lexicon.size() == 0) begin
        w = rand_word(1, 8, $urandom_range(0, 1) ? 4 : 26);
        push_word(w, W_INSERT);
        keep_word(w);
      end else if (r < 65) begin
        w = lexicon[$urandom_range(0, lexicon.size() - 1)];
        push_word(w, W_LOOKUP);
      end else if (r < 75) begin
        w = lexicon[$urandom_range(0, lexicon.size() - 1)];
        // prefix or one letter longer: both should miss unless marked
        if (w.len > 1 && $urandom_range(0, 1)) begin
          w.len = w.len - 5'd1;
        end else if (w.len < MAX_WORD) begin
          w.ch[w.len] = 5'($urandom_range(0, 25));
          w.len = w.len + 5'd1;
        end
        push_word(w, W_LOOKUP);
      end else if (r < 85) begin
        w = rand_word(1, 6, 26);
        push_word(w, W_LOOKUP);
      end else if (r < 95) begin
        w = rand_word(1, 6, 4);
        push_word(w, W_MIXED);
      end else begin
        w = lexicon[$urandom_range(0, lexicon.size() - 1)];
        push_word(w, W_INSERT);
      end
      used += w.len;
    end
  endtask

  // sender
  always @(posedge clk) begin
    letter_beat_t cur;
    trie_answer_t ans;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_if.operation <= tli_pkg::OP_INSERT;
      req_if.letter <= 5'd0;
      req_if.last_letter <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        if (trie_walk(req_if.operation, req_if.letter, req_if.last_letter, ans))
          answers_due = {answers_due, ans};
        letters_sent++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (letters_todo.size() != 0) begin
          cur = letters_todo.pop_front();
          req_if.valid <= 1'b1;
          req_if.operation <= cur.op;
          req_if.letter <= cur.letter;
          req_if.last_letter <= cur.last;
          send_gap = draw_wait(send_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-offs so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && results_got >= next_hold_at) begin
      hold_left <= HOLD_LEN;
      holds_done <= holds_done + 1;
      next_hold_at <= next_hold_at + 200;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    trie_answer_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_got++;
        status_seen[rsp_if.status]++;
        if (answers_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result beat status=%s nodes_used=%0d", $realtime,
                     rsp_if.status.name(), rsp_if.nodes_used);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (rsp_if.status !== want.status || rsp_if.nodes_used !== want.nodes_used) begin
            if (fail_count < 10)
              $display("%0t: result %0d mismatch: status exp %s got %s, nodes_used exp %0d got %0d",
                       $realtime, results_got, want.status.name(), rsp_if.status.name(),
                       want.nodes_used, rsp_if.nodes_used);
            fail_count++;
          end
        end
        recv_stall = draw_wait(recv_calm);
      end else if (recv_stall != 0) begin
        recv_stall--;
      end
      rsp_if.ready <= (recv_stall == 0) && (hold_left == 0);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_cnt, answers_due.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    word_t w;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed words
    push_letter(tli_pkg::OP_LOOKUP, 5'd0, 1'b1);   // empty trie
    push_letter(tli_pkg::OP_INSERT, 5'd0, 1'b1);
    push_letter(tli_pkg::OP_LOOKUP, 5'd0, 1'b1);
    push_letter(tli_pkg::OP_INSERT, 5'd25, 1'b0);  // letter past z folds onto z
    push_letter(tli_pkg::OP_INSERT, 5'd31, 1'b1);
    push_letter(tli_pkg::OP_LOOKUP, 5'd25, 1'b0);
    push_letter(tli_pkg::OP_LOOKUP, 5'd26, 1'b1);
    push_letter(tli_pkg::OP_LOOKUP, 5'd25, 1'b1);  // prefix with no word mark
    push_letter(tli_pkg::OP_LOOKUP, 5'd0, 1'b0);   // mixed ops within a word
    push_letter(tli_pkg::OP_INSERT, 5'd1, 1'b1);
    push_letter(tli_pkg::OP_LOOKUP, 5'd0, 1'b0);
    push_letter(tli_pkg::OP_LOOKUP, 5'd1, 1'b1);
    push_letter(tli_pkg::OP_INSERT, 5'd16, 1'b0);
    push_letter(tli_pkg::OP_LOOKUP, 5'd23, 1'b1);
    push_letter(tli_pkg::OP_LOOKUP, 5'd12, 1'b0);  // missing path, then insert on broken path
    push_letter(tli_pkg::OP_INSERT, 5'd13, 1'b1);
    push_letter(tli_pkg::OP_INSERT, 5'd26, 1'b0);
    push_letter(tli_pkg::OP_INSERT, 5'd27, 1'b0);
    push_letter(tli_pkg::OP_INSERT, 5'd28, 1'b1);
    push_letter(tli_pkg::OP_LOOKUP, 5'd29, 1'b0);
    push_letter(tli_pkg::OP_LOOKUP, 5'd30, 1'b1);
    push_letter(tli_pkg::OP_LOOKUP, 5'd12, 1'b0);
    push_letter(tli_pkg::OP_LOOKUP, 5'd13, 1'b1);

    mixed_words(150);

    // long inserts until every node is taken
    while (free_next < NODE_COUNT) begin
      w = rand_word(20, MAX_WORD, 26);
      push_word(w, W_INSERT);
      keep_word(w);
      while (letters_sent != letters_pushed) @(posedge clk);
    end

    // full table: known words still insert, new ones fail
    mixed_words(200);

    while (letters_sent != letters_pushed) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d letters sent, %0d words answered, %0d nodes in use", letters_sent,
             results_got, free_next);
    $display("answers: %0d inserted, %0d found, %0d not found, %0d full; %0d mismatches",
             status_seen[tli_pkg::ST_INSERTED], status_seen[tli_pkg::ST_FOUND],
             status_seen[tli_pkg::ST_NOT_FOUND], status_seen[tli_pkg::ST_FULL], fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
